>>> src/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the CAN signal extract decoder
// Field widths, register indexes, layout bit positions, queue sizes and the
// packed beat types for the input, result, configuration and inner queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

    // frame and arithmetic geometry
    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int FRAC_BITS     = 16;
    localparam int PROD_W        = 64;
    localparam int RAW_W         = 32;
    localparam int MAX_FIELD_LEN = 32;

    localparam int ID_W     = 29;
    localparam int DLC_W    = 4;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 17;
    localparam int COEF_W   = 32;
    localparam int LAYOUT_W = 15;
    localparam int POS_W    = 7;

    localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LAYOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 3'd6;

    // layout register bits
    localparam int LAY_BIG_ENDIAN = 12;
    localparam int LAY_ENABLE     = 13;
    localparam int LAY_ZERO_STALE = 14;

    // opcodes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // inner queue between front and back
    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = 2;
    localparam int MQ_CNT_W = 3;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic                 opcode;
        logic [ID_W-1:0]      frame_id;
        logic [DLC_W-1:0]     frame_length;
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    now_ms;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] signal_value;
        logic                    signal_valid;
        logic                    frame_matched;
        logic                    went_stale;
    } result_t;

    typedef struct packed {
        logic [LAYOUT_W-1:0]      signal_layout;
        logic [ID_W-1:0]          match_id;
        logic signed [COEF_W-1:0] scale_q16;
        logic signed [COEF_W-1:0] offset_q16;
        logic signed [VAL_W-1:0]  clamp_low;
        logic signed [VAL_W-1:0]  clamp_high;
        logic [TIME_W-1:0]        stale_timeout_ms;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic              is_tick;
        logic              hit;
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] now_ms;
    } entry_t;

endpackage

`default_nettype wire

>>> src/can_signal_extract_decoder.sv
// ----------------------------------------------------------------------------
// can_signal_extract_decoder: one CAN signal lane
// Extracts a configured bit field from matching frames, scales it in Q16.16,
// clamps and holds it, and expires it on time ticks past the timeout.
// ----------------------------------------------------------------------------
// Rate: one input beat per clock, sustained as long as results
// are popped. Every accepted beat (frame or tick) gives exactly one result
// beat, in order. An accepted input beat passes through the front queue,
// the 33x32 multiplier stage and the offset adder stage, after which the
// truncate/clamp/state-update stage writes the result queue. The result
// queue holds four beats; with two beats always able to be in flight, the
// back stops drawing from the front queue when the consumer falls behind,
// and full rises once the four-entry front queue also fills. Configuration
// writes take effect at the next clock and are meant to be made while the
// lane is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_extract_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input queue side
    input  wire logic                           push,
    output logic                                full,
    input  cse_pkg::item_t                      item,
    // result queue side
    output logic                                empty,
    input  wire logic                           pop,
    output cse_pkg::result_t                    result,
    // configuration write port
    input  wire logic                           cfg_write,
    input  wire logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cse_pkg::CFG_DATA_W-1:0] cfg_data
);

    cse_pkg::cfg_t   cfg;
    cse_pkg::entry_t front_entry;
    cse_pkg::entry_t head_entry;
    logic            mq_empty;
    logic            back_take;

    cse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: classify and extract the raw field on the way in
    cse_front u_front (
        .item  (item),
        .cfg   (cfg),
        .entry (front_entry)
    );

    // decouples input beats from the value pipeline
    cse_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (front_entry),
        .rd    (back_take),
        .rdata (head_entry),
        .full  (full),
        .empty (mq_empty)
    );

    // back: scale, offset, clamp, lane state, result queue
    cse_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .entry  (head_entry),
        .avail  (!mq_empty),
        .take   (back_take),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

`default_nettype wire

>>> src/cse_cfg_regs.sv
// ----------------------------------------------------------------------------
// cse_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port, held as one struct.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cse_pkg::CFG_DATA_W-1:0] cfg_data,
    output cse_pkg::cfg_t                       cfg
);

    cse_pkg::cfg_t cfg_reg;
    cse_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cse_pkg::REG_SIGNAL_LAYOUT:
                    cfg_next.signal_layout = cfg_data[cse_pkg::LAYOUT_W-1:0];
                cse_pkg::REG_MATCH_ID:
                    cfg_next.match_id = cfg_data[cse_pkg::ID_W-1:0];
                cse_pkg::REG_SCALE:
                    cfg_next.scale_q16 = cfg_data[cse_pkg::COEF_W-1:0];
                cse_pkg::REG_OFFSET:
                    cfg_next.offset_q16 = cfg_data[cse_pkg::COEF_W-1:0];
                cse_pkg::REG_CLAMP_LOW:
                    cfg_next.clamp_low = cfg_data[cse_pkg::VAL_W-1:0];
                cse_pkg::REG_CLAMP_HIGH:
                    cfg_next.clamp_high = cfg_data[cse_pkg::VAL_W-1:0];
                cse_pkg::REG_STALE_TIMEOUT:
                    cfg_next.stale_timeout_ms = cfg_data[cse_pkg::TIME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signal_layout    <= '0;
            cfg_reg.match_id         <= '0;
            cfg_reg.scale_q16        <= 32'sd65536;
            cfg_reg.offset_q16       <= '0;
            cfg_reg.clamp_low        <= '0;
            cfg_reg.clamp_high       <= 17'sd65535;
            cfg_reg.stale_timeout_ms <= 32'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front: item classifier
// Checks identifier, enable and field fit, and pulls the raw field out of the
// payload with a barrel shift (Intel) or a byte swap and shift (Motorola).
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front (
    input  cse_pkg::item_t  item,
    input  cse_pkg::cfg_t   cfg,
    output cse_pkg::entry_t entry
);

    logic [5:0]                      start;
    logic [5:0]                      len;
    logic [5:0]                      first_pos;
    logic                            big;
    logic [cse_pkg::DLC_W-1:0]       bytes;
    logic [cse_pkg::POS_W-1:0]       limit;
    logic [cse_pkg::POS_W-1:0]       last_pos;
    logic [cse_pkg::POS_W-1:0]       mot_shift;
    logic [cse_pkg::PAYLOAD_W-1:0]   swapped;
    logic [cse_pkg::PAYLOAD_W-1:0]   shifted;
    logic [cse_pkg::RAW_W-1:0]       mask;
    logic                            fits;

    always_comb
    begin
        start = cfg.signal_layout[5:0];
        len   = cfg.signal_layout[11:6];
        big   = cfg.signal_layout[cse_pkg::LAY_BIG_ENDIAN];

        if (item.frame_length > cse_pkg::DLC_W'(cse_pkg::PAYLOAD_BYTES))
            bytes = cse_pkg::DLC_W'(cse_pkg::PAYLOAD_BYTES);
        else
            bytes = item.frame_length;
        limit = {bytes, 3'b000};

        // Motorola walk is linear in byte-major, MSB-first bit order
        first_pos = big ? (start ^ 6'd7) : start;
        last_pos  = {1'b0, first_pos} + {1'b0, len} - cse_pkg::POS_W'(1);
        fits      = (len != 6'd0) && (len <= 6'(cse_pkg::MAX_FIELD_LEN)) &&
                    (last_pos < limit);

        for (int k = 0; k < cse_pkg::PAYLOAD_BYTES; k++)
        begin
            swapped[8*(cse_pkg::PAYLOAD_BYTES-1-k) +: 8] = item.payload[8*k +: 8];
        end
        mot_shift = cse_pkg::POS_W'(cse_pkg::PAYLOAD_W) - {1'b0, first_pos} - {1'b0, len};

        if (big)
            shifted = swapped >> mot_shift;
        else
            shifted = item.payload >> first_pos;

        mask = {cse_pkg::RAW_W{1'b1}} >> (6'(cse_pkg::MAX_FIELD_LEN) - len);

        entry.is_tick = (item.opcode == cse_pkg::OP_TICK);
        entry.hit     = (item.opcode == cse_pkg::OP_FRAME) &&
                        cfg.signal_layout[cse_pkg::LAY_ENABLE] &&
                        (item.frame_id == cfg.match_id) && fits;
        entry.raw     = shifted[cse_pkg::RAW_W-1:0] & mask;
        entry.now_ms  = item.now_ms;
    end

endmodule

`default_nettype wire

>>> src/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue: short queue between classifier and value pipeline
// Register-array FIFO with head shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  cse_pkg::entry_t wdata,
    input  wire logic       rd,
    output cse_pkg::entry_t rdata,
    output logic            full,
    output logic            empty
);

    cse_pkg::entry_t mem [cse_pkg::MQ_DEPTH];

    logic [cse_pkg::MQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cse_pkg::MQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cse_pkg::MQ_CNT_W-1:0] count_reg, count_next;
    logic                         do_wr;
    logic                         do_rd;

    assign full  = (count_reg == cse_pkg::MQ_CNT_W'(cse_pkg::MQ_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + cse_pkg::MQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + cse_pkg::MQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + cse_pkg::MQ_CNT_W'(do_wr) - cse_pkg::MQ_CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back: value pipeline, lane state and result queue
// Multiply, offset add, then truncate/clamp with the state update; results
// go to a small queue. Issue is credit-limited so the queue never overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cse_pkg::cfg_t    cfg,
    input  cse_pkg::entry_t  entry,
    input  wire logic        avail,
    output logic             take,
    input  wire logic        pop,
    output logic             empty,
    output cse_pkg::result_t result
);

    // stage 1: product
    logic                               s1_valid_reg;
    logic                               s1_tick_reg;
    logic                               s1_hit_reg;
    logic [cse_pkg::TIME_W-1:0]         s1_now_reg;
    logic signed [cse_pkg::PROD_W-1:0]  s1_prod_reg;
    logic signed [cse_pkg::PROD_W:0]    prod_full;

    // stage 2: sum
    logic                               s2_valid_reg;
    logic                               s2_tick_reg;
    logic                               s2_hit_reg;
    logic [cse_pkg::TIME_W-1:0]         s2_now_reg;
    logic signed [cse_pkg::PROD_W-1:0]  s2_sum_reg;
    logic signed [cse_pkg::PROD_W-1:0]  offset_ext;

    // lane state
    logic [cse_pkg::TIME_W-1:0]         last_seen_reg, last_seen_next;
    logic                               seen_reg, seen_next;
    logic signed [cse_pkg::VAL_W-1:0]   held_reg, held_next;
    logic                               valid_reg, valid_next;

    logic signed [cse_pkg::PROD_W-1:0]  trunc;
    logic signed [cse_pkg::PROD_W-1:0]  lo_ext;
    logic signed [cse_pkg::PROD_W-1:0]  hi_ext;
    logic signed [cse_pkg::VAL_W-1:0]   clamped;
    logic [cse_pkg::TIME_W-1:0]         elapsed;
    logic                               expire;
    logic                               round_up;
    cse_pkg::result_t                   res_new;

    // result queue
    cse_pkg::result_t                   oq_mem [cse_pkg::OQ_DEPTH];
    logic [cse_pkg::OQ_PTR_W-1:0]       oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [cse_pkg::OQ_PTR_W-1:0]       oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [cse_pkg::OQ_CNT_W-1:0]       oq_count_reg, oq_count_next;
    logic [cse_pkg::OQ_CNT_W-1:0]       committed;
    logic                               oq_rd;

    // credits: stored results plus both stages in flight
    always_comb
    begin
        committed = oq_count_reg + cse_pkg::OQ_CNT_W'(s1_valid_reg)
                  + cse_pkg::OQ_CNT_W'(s2_valid_reg);
        take      = avail && (committed < cse_pkg::OQ_CNT_W'(cse_pkg::OQ_DEPTH));
    end

    assign prod_full  = $signed({1'b0, entry.raw}) * cfg.scale_q16;
    assign offset_ext = {{(cse_pkg::PROD_W-cse_pkg::COEF_W){cfg.offset_q16[cse_pkg::COEF_W-1]}},
                         cfg.offset_q16};

    always_ff @(posedge clk)
    begin
        s1_tick_reg <= entry.is_tick;
        s1_hit_reg  <= entry.hit;
        s1_now_reg  <= entry.now_ms;
        s1_prod_reg <= prod_full[cse_pkg::PROD_W-1:0];
        s2_tick_reg <= s1_tick_reg;
        s2_hit_reg  <= s1_hit_reg;
        s2_now_reg  <= s1_now_reg;
        s2_sum_reg  <= s1_prod_reg + offset_ext;
    end

    // stage 3: truncate toward zero, clamp, update lane state
    always_comb
    begin
        round_up = s2_sum_reg[cse_pkg::PROD_W-1] &&
                   ((s2_sum_reg & cse_pkg::FRAC_MASK) != '0);
        trunc    = (s2_sum_reg >>> cse_pkg::FRAC_BITS) +
                   $signed(cse_pkg::PROD_W'(round_up));
        lo_ext   = {{(cse_pkg::PROD_W-cse_pkg::VAL_W){cfg.clamp_low[cse_pkg::VAL_W-1]}},
                    cfg.clamp_low};
        hi_ext   = {{(cse_pkg::PROD_W-cse_pkg::VAL_W){cfg.clamp_high[cse_pkg::VAL_W-1]}},
                    cfg.clamp_high};

        // when the limits cross, values below the low limit get it, all others the high limit
        if (trunc < lo_ext)
            clamped = cfg.clamp_low;
        else if (trunc > hi_ext)
            clamped = cfg.clamp_high;
        else
            clamped = trunc[cse_pkg::VAL_W-1:0];

        elapsed = s2_now_reg - last_seen_reg;
        expire  = s2_tick_reg && seen_reg && (elapsed > cfg.stale_timeout_ms);

        last_seen_next = last_seen_reg;
        seen_next      = seen_reg;
        held_next      = held_reg;
        valid_next     = valid_reg;

        if (s2_valid_reg)
        begin
            if (!s2_tick_reg && s2_hit_reg)
            begin
                held_next      = clamped;
                valid_next     = 1'b1;
                seen_next      = 1'b1;
                last_seen_next = s2_now_reg;
            end
            else if (expire)
            begin
                seen_next  = 1'b0;
                valid_next = 1'b0;
                if (cfg.signal_layout[cse_pkg::LAY_ZERO_STALE])
                    held_next = '0;
            end
        end

        res_new.signal_value  = held_next;
        res_new.signal_valid  = valid_next;
        res_new.frame_matched = !s2_tick_reg && s2_hit_reg;
        res_new.went_stale    = expire;
    end

    assign empty  = (oq_count_reg == '0);
    assign oq_rd  = pop && !empty;
    assign result = oq_mem[oq_rd_ptr_reg];

    always_comb
    begin
        oq_wr_ptr_next = s2_valid_reg ? oq_wr_ptr_reg + cse_pkg::OQ_PTR_W'(1) : oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_rd ? oq_rd_ptr_reg + cse_pkg::OQ_PTR_W'(1) : oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg + cse_pkg::OQ_CNT_W'(s2_valid_reg)
                       - cse_pkg::OQ_CNT_W'(oq_rd);
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            oq_mem[oq_wr_ptr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            last_seen_reg <= '0;
            seen_reg      <= 1'b0;
            held_reg      <= '0;
            valid_reg     <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= take;
            s2_valid_reg  <= s1_valid_reg;
            last_seen_reg <= last_seen_next;
            seen_reg      <= seen_next;
            held_reg      <= held_next;
            valid_reg     <= valid_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker: port-level checks for the CAN signal extract decoder
// Tracks beats accepted vs delivered; checks flag consistency and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       pop,
    input wire logic       empty,
    input cse_pkg::result_t result
);

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg + 4'(push && !full) - 4'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // no result beat without an accepted input beat behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != 4'd0))
        else $error("result beat without a pending input beat");

    a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_matched) |-> (result.signal_valid && !result.went_stale))
        else $error("matched frame must leave the signal valid");

    a_stale_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.went_stale) |-> !result.signal_valid)
        else $error("expired signal still flagged valid");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result beat changed or vanished");

endmodule

bind can_signal_extract_decoder cse_checker u_cse_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire
